// ----- rtl/core/idsk_pkg.sv -----
`timescale 1ns / 1ps

package idsk_pkg;

  // Default geometry of the stack
  localparam int unsigned DEPTH_DEF     = 8;
  localparam int unsigned WORD_BITS_DEF = 32;

  // Fixed port widths
  localparam int unsigned CMD_W = 3;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned CNT_W = 4;

  // Request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the request fields
    logic exec;  // carry out the captured request
  } ctrl_t;

endpackage

// ----- rtl/core/idsk_ctrl.sv -----
`timescale 1ns / 1ps

module idsk_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  output logic                 done_o,
  output idsk_pkg::ctrl_t      ctrl_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // Sequence: capture the request, then execute it in the following cycle
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Flag the result in the cycle after execution
  assign done_d = (state_q == S_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign ctrl_o.load = (state_q == S_IDLE) && start;
  assign ctrl_o.exec = (state_q == S_EXEC);

endmodule

// ----- rtl/core/idsk_dp.sv -----
`timescale 1ns / 1ps

module idsk_dp #(
  parameter int unsigned DEPTH     = idsk_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = idsk_pkg::WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  idsk_pkg::ctrl_t             ctrl_i,
  input  logic [idsk_pkg::CMD_W-1:0]  command_i,
  input  logic [idsk_pkg::VAL_W-1:0]  value_i,
  input  logic [idsk_pkg::IDX_W-1:0]  index_i,
  output logic [idsk_pkg::VAL_W-1:0]  read_value_o,
  output logic [idsk_pkg::ST_W-1:0]   status_o,
  output logic [idsk_pkg::CNT_W-1:0]  count_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > idsk_pkg::IDX_W) ? CW : idsk_pkg::IDX_W;

  // Captured request
  idsk_pkg::cmd_e                cmd_q;
  logic [idsk_pkg::VAL_W-1:0]    val_q;
  logic [idsk_pkg::IDX_W-1:0]    idx_q;

  // Stack cells and fill count
  logic [WORD_BITS-1:0]          cell_q [DEPTH];
  logic [WORD_BITS-1:0]          cell_d [DEPTH];
  logic [CW-1:0]                 count_q, count_d;

  // Result registers
  logic [idsk_pkg::VAL_W-1:0]    rd_q, rd_d;
  idsk_pkg::status_e             st_q, st_d;

  logic [CMPW-1:0]               idx_w, cnt_w;
  logic                          full, empty;
  logic                          do_grow, do_shrink, do_read;
  logic                          top_sel;
  logic [AW-1:0]                 pos;
  logic [WORD_BITS-1:0]          wval;

  // Hold the request fields
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= idsk_pkg::cmd_e'(command_i);
      val_q <= value_i;
      idx_q <= index_i;
    end
  end

  assign idx_w = CMPW'(idx_q);
  assign cnt_w = CMPW'(count_q);
  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);
  assign wval  = WORD_BITS'(val_q);

  // Decode the command into status and a grow, shrink or read action
  always_comb begin
    st_d      = idsk_pkg::ST_OK;
    do_grow   = 1'b0;
    do_shrink = 1'b0;
    do_read   = 1'b0;
    top_sel   = 1'b0;
    unique case (cmd_q)
      idsk_pkg::CMD_PUSH: begin
        top_sel = 1'b1;
        if (full) st_d = idsk_pkg::ST_FULL;
        else      do_grow = 1'b1;
      end
      idsk_pkg::CMD_POP: begin
        top_sel = 1'b1;
        if (empty) st_d = idsk_pkg::ST_EMPTY;
        else begin
          do_shrink = 1'b1;
          do_read   = 1'b1;
        end
      end
      idsk_pkg::CMD_PEEK: begin
        top_sel = 1'b1;
        if (empty) st_d = idsk_pkg::ST_EMPTY;
        else       do_read = 1'b1;
      end
      idsk_pkg::CMD_INSERT: begin
        if (full)               st_d = idsk_pkg::ST_FULL;
        else if (idx_w > cnt_w) st_d = idsk_pkg::ST_RANGE;
        else                    do_grow = 1'b1;
      end
      idsk_pkg::CMD_REMOVE: begin
        if (empty)               st_d = idsk_pkg::ST_EMPTY;
        else if (idx_w >= cnt_w) st_d = idsk_pkg::ST_RANGE;
        else begin
          do_shrink = 1'b1;
          do_read   = 1'b1;
        end
      end
      idsk_pkg::CMD_READ: begin
        if (empty)               st_d = idsk_pkg::ST_EMPTY;
        else if (idx_w >= cnt_w) st_d = idsk_pkg::ST_RANGE;
        else                     do_read = 1'b1;
      end
      default: begin
        st_d = idsk_pkg::ST_OK;
      end
    endcase
  end

  // Select the working position: top of stack or the requested index
  always_comb begin
    if (top_sel) begin
      pos = (cmd_q == idsk_pkg::CMD_PUSH) ? AW'(count_q) : AW'(count_q - CW'(1));
    end else begin
      pos = AW'(idx_q);
    end
  end

  assign rd_d = do_read ? idsk_pkg::VAL_W'(cell_q[pos]) : '0;

  // Next value of each cell: shift up over the insert point, down from the
  // removal point; cells above the count are zero so vacated cells clear
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] below, above;
    if (g == 0) begin : g_bot
      assign below = '0;
    end else begin : g_mid_b
      assign below = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_top
      assign above = '0;
    end else begin : g_mid_a
      assign above = cell_q[g+1];
    end

    always_comb begin
      cell_d[g] = cell_q[g];
      if (do_grow) begin
        if (AW'(g) == pos)     cell_d[g] = wval;
        else if (AW'(g) > pos) cell_d[g] = below;
      end else if (do_shrink) begin
        if (AW'(g) >= pos) cell_d[g] = above;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cell_q[g] <= '0;
      end else if (ctrl_i.exec) begin
        cell_q[g] <= cell_d[g];
      end
    end
  end

  // Advance the fill count
  always_comb begin
    count_d = count_q;
    if (do_grow)        count_d = count_q + CW'(1);
    else if (do_shrink) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.exec) begin
      count_q <= count_d;
    end
  end

  // Register the result fields
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      rd_q <= rd_d;
      st_q <= st_d;
    end
  end

  assign read_value_o = rd_q;
  assign status_o     = st_q;
  assign count_o      = idsk_pkg::CNT_W'(count_q);

endmodule

// ----- rtl/core/indexed_data_stack.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Ports
// request   in         start & !busy       command_i, value_i, index_i
// result    out        done_o (one cycle)  read_value_o, status_o, count_o
//
// Each request is captured at the accepting edge, the controller executes it
// in the next cycle, and done_o is high in the cycle after that. All cells
// shift in the execute cycle. busy is high only during execute, so a new
// request may be taken while done_o is shown. Reset clears every cell and the
// count. The receiver cannot stall results.

module indexed_data_stack #(
  parameter int unsigned DEPTH     = idsk_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = idsk_pkg::WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [idsk_pkg::CMD_W-1:0]  command_i,
  input  logic [idsk_pkg::VAL_W-1:0]  value_i,
  input  logic [idsk_pkg::IDX_W-1:0]  index_i,
  output logic                        done_o,
  output logic [idsk_pkg::VAL_W-1:0]  read_value_o,
  output logic [idsk_pkg::ST_W-1:0]   status_o,
  output logic [idsk_pkg::CNT_W-1:0]  count_o
);

  idsk_pkg::ctrl_t ctrl;

  // Sequence the requests
  idsk_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .ctrl_o (ctrl)
  );

  // Hold the stack and compute results
  idsk_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .command_i    (command_i),
    .value_i      (value_i),
    .index_i      (index_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .count_o      (count_o)
  );

endmodule
